/* hw/rtl/hcc_pkg.sv */
// Shared types and constants for the 3x3 Hill cipher encryptor.
package hcc_pkg;

  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned KEY_ROW_W   = 15;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [7:0] ASCII_LOWER_A = 8'd97;
  localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
  localparam logic [LETTER_W-1:0] PAD_INDEX = 5'd23;
  localparam logic [4:0] LETTER_COUNT = 5'd26;
  localparam logic [13:0] MOD26_RECIP = 14'd2521;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ROW_ZERO = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ROW_ONE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ROW_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0][LETTER_W-1:0] letters;
    logic [1:0]               count;
  } group_t;

  typedef struct packed {
    logic [2:0][KEY_ROW_W-1:0] rows;
  } key_t;

endpackage

/* hw/rtl/hcc_front.sv */
// Front end: letter filter, group collection and end-of-text padding.
module hcc_front
  import hcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   text_byte,
  input  logic         end_of_text,
  output logic         push,
  output group_t       group
);

  logic [1:0]               fill;
  logic [1:0]               fill_next;
  logic [2:0][LETTER_W-1:0] letters;
  logic [2:0][LETTER_W-1:0] letters_next;
  logic                     is_letter;
  logic [2:0]               fill_inc;
  logic [7:0]               offset;

  always_comb begin
    is_letter    = (text_byte >= ASCII_LOWER_A) && (text_byte <= ASCII_LOWER_Z);
    offset       = text_byte - ASCII_LOWER_A;
    letters_next = letters;
    if (is_letter) begin
      letters_next[fill] = offset[LETTER_W-1:0];
    end
    fill_inc     = {1'b0, fill} + {2'b00, is_letter};
    push         = 1'b0;
    group.count  = fill_inc[1:0];
    fill_next    = fill_inc[1:0];
    if (fill_inc == 3'd3) begin
      push        = accept;
      group.count = 2'd3;
      fill_next   = 2'd0;
    end else if (end_of_text && (fill_inc != 3'd0)) begin
      push = accept;
      for (int k = 1; k < 3; k++) begin
        if (k >= int'(fill_inc)) begin
          letters_next[k] = PAD_INDEX;
        end
      end
      fill_next = 2'd0;
    end
    group.letters = letters_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      letters <= letters_next;
    end
  end

endmodule

/* hw/rtl/hcc_queue.sv */
// Short group queue between front end and cipher back end.
module hcc_queue
  import hcc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_data,
  input  logic   pop,
  output logic   pop_valid,
  output group_t pop_data,
  output logic   full
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  group_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* hw/rtl/hcc_back.sv */
// Back end: key row products, mod 26 reduction and result output register.
module hcc_back
  import hcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  key_t       key,
  input  logic       q_valid,
  input  group_t     q_data,
  output logic       q_pop,
  output logic       cipher_valid,
  input  logic       cipher_stall,
  output logic [6:0] cipher_byte,
  output logic       last_of_run
);

  group_t      cur;
  logic        cur_valid;
  logic [1:0]  row;
  logic [11:0] sum;
  logic        sum_valid;
  logic        sum_last;

  logic        out_load;
  logic        sum_ready;
  logic        issue;
  logic        last_row;
  logic [11:0] row_sum;
  logic [14:0] key_row;
  logic [22:0] recip_prod;
  logic [6:0]  quot;
  logic [11:0] rem_wide;
  logic [7:0]  ascii;

  assign out_load  = !cipher_valid || !cipher_stall;
  assign sum_ready = !sum_valid || out_load;
  assign issue     = cur_valid && sum_ready;
  assign last_row  = (row == (cur.count - 2'd1));
  assign q_pop     = q_valid && (!cur_valid || (issue && last_row));

  always_comb begin
    case (row)
      2'd0:    key_row = key.rows[0];
      2'd1:    key_row = key.rows[1];
      default: key_row = key.rows[2];
    endcase
    row_sum = '0;
    for (int c = 0; c < 3; c++) begin
      row_sum = row_sum + 12'(key_row[5*c +: 5]) * 12'(cur.letters[c]);
    end
  end

  always_comb begin
    recip_prod = 23'(sum) * 23'(MOD26_RECIP);
    quot       = recip_prod[22:16];
    rem_wide   = sum - 12'(quot) * 12'(LETTER_COUNT);
    ascii      = ASCII_LOWER_A + {3'b000, rem_wide[4:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      row       <= 2'd0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      row       <= 2'd0;
    end else if (issue && last_row) begin
      cur_valid <= 1'b0;
    end else if (issue) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready) begin
      sum      <= row_sum;
      sum_last <= last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_valid <= 1'b0;
    end else if (out_load) begin
      cipher_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cipher_byte <= ascii[6:0];
      last_of_run <= sum_last;
    end
  end

endmodule

/* hw/rtl/hill_cipher_3x3_encrypt_top.sv */
// Top level of the 3x3 Hill cipher encryptor.
// Accepts one text byte per cycle while the group queue has room.
// After the byte that closes a group, its first result passes the queue, entry and sum stages to the output register.
// The back end emits one result per cycle while groups are waiting and cipher_stall is low.
// Reset clears group fill, queue, pipeline valids and all key rows at once.
module hill_cipher_3x3_encrypt_top
  import hcc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  logic [7:0]             text_byte,
  input  logic                   end_of_text,
  output logic                   cipher_valid,
  input  logic                   cipher_stall,
  output logic [6:0]             cipher_byte,
  output logic                   last_of_run,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [KEY_ROW_W-1:0]   cfg_data
);

  key_t   key;
  logic   accept;
  logic   push;
  group_t group;
  logic   q_full;
  logic   q_valid;
  group_t q_data;
  logic   q_pop;

  assign cfg_ready  = 1'b1;
  assign text_stall = q_full;
  assign accept     = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_ROW_ZERO: key.rows[0] <= cfg_data;
        CFG_KEY_ROW_ONE:  key.rows[1] <= cfg_data;
        CFG_KEY_ROW_TWO:  key.rows[2] <= cfg_data;
        default:          key <= key;
      endcase
    end
  end

  hcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .push        (push),
    .group       (group)
  );

  hcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (group),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .full      (q_full)
  );

  hcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .key          (key),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher_byte  (cipher_byte),
    .last_of_run  (last_of_run)
  );

endmodule

/* hw/rtl/hcc_checker.sv */
// Port-level checks for the Hill cipher encryptor, bound to the top level.
module hcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       text_stall,
  input logic       cipher_valid,
  input logic       cipher_stall,
  input logic [6:0] cipher_byte,
  input logic       last_of_run
);

  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    cipher_valid |-> (cipher_byte >= 7'd97) && (cipher_byte <= 7'd122))
    else $error("cipher byte outside lowercase range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    cipher_valid && cipher_stall |=>
      cipher_valid && $stable(cipher_byte) && $stable(last_of_run))
    else $error("stalled result changed");

  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !cipher_valid)
    else $error("result shown straight after reset");

  a_reset_no_stall: assert property (@(posedge clk)
    rst |=> !text_stall)
    else $error("input stalled straight after reset");

endmodule

bind hill_cipher_3x3_encrypt_top hcc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .text_stall   (text_stall),
  .cipher_valid (cipher_valid),
  .cipher_stall (cipher_stall),
  .cipher_byte  (cipher_byte),
  .last_of_run  (last_of_run)
);

/* verif/hill_cipher_3x3_encrypt_top_test.sv */
// Self-checking testbench for the 3x3 Hill cipher encryptor: directed, back-pressure and random.
module hill_cipher_3x3_encrypt_top_test;
  import hcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   text_valid = 1'b0;
  logic                   text_stall;
  logic [7:0]             text_byte = '0;
  logic                   end_of_text = 1'b0;
  logic                   cipher_valid;
  logic                   cipher_stall = 1'b0;
  logic [6:0]             cipher_byte;
  logic                   last_of_run;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [KEY_ROW_W-1:0]   cfg_data = '0;

  logic [KEY_ROW_W-1:0] key_rows [3] = '{default: '0};
  logic [LETTER_W-1:0]  group_idx [3] = '{default: '0};
  logic [1:0]           group_len = '0;
  cipher_out_t          pending_cipher [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int bytes_sent = 0;
  int letters_checked = 0;
  int key_loads = 0;

  hill_cipher_3x3_encrypt_top u_top (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .cipher_valid (cipher_valid),
    .cipher_stall (cipher_stall),
    .cipher_byte  (cipher_byte),
    .last_of_run  (last_of_run),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hold the output stalled while a long hold-off is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      cipher_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      cipher_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_cipher
    cipher_out_t want;
    if (!rst && cipher_valid && !cipher_stall) begin
      if (pending_cipher.size() == 0) begin
        $error("cipher_byte: no letter expected, got %0d", cipher_byte);
        errors++;
      end else begin
        want = pending_cipher.pop_front();
        if (cipher_byte !== want.letter) begin
          $error("cipher_byte: expected %0d, got %0d", want.letter, cipher_byte);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
          errors++;
        end
        letters_checked++;
      end
    end
  end

  task automatic encrypt_char(input logic [7:0] b, input logic eot);
    int emit;
    int acc;
    emit = 0;
    if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
      group_idx[group_len] = LETTER_W'(b - ASCII_LOWER_A);
      group_len++;
      if (group_len == 2'd3) begin
        emit = 3;
        group_len = '0;
      end
    end
    if (emit == 0 && eot && group_len != '0) begin
      emit = group_len;
      for (int k = group_len; k < 3; k++) group_idx[k] = PAD_INDEX;
      group_len = '0;
    end
    for (int row = 0; row < emit; row++) begin
      acc = 0;
      for (int col = 0; col < 3; col++)
        acc += int'(key_rows[row][col*LETTER_W +: LETTER_W]) * int'(group_idx[col]);
      pending_cipher.push_back('{7'(int'(ASCII_LOWER_A) + acc % int'(LETTER_COUNT)),
                                 row == emit - 1});
    end
  endtask

  task automatic send_text_byte(input logic [7:0] b, input logic eot);
    int gap;
    text_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    do @(posedge clk); while (text_stall);
    encrypt_char(b, eot);
    bytes_sent++;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text_string(input string s, input bit eot_on_last);
    for (int i = 0; i < s.len(); i++)
      send_text_byte(s[i], eot_on_last && i == s.len() - 1);
  endtask

  task automatic wait_drain();
    int spins;
    spins = 0;
    text_valid <= 1'b0;
    while (pending_cipher.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
    if (pending_cipher.size() != 0) begin
      $error("cipher_byte: %0d letters never arrived", pending_cipher.size());
      errors++;
      pending_cipher.delete();
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic load_key_row(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [KEY_ROW_W-1:0] row);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= row;
    do @(posedge clk); while (!cfg_ready);
    key_rows[idx] = row;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [KEY_ROW_W-1:0] r0, input logic [KEY_ROW_W-1:0] r1,
                          input logic [KEY_ROW_W-1:0] r2);
    load_key_row(CFG_KEY_ROW_ZERO, r0);
    load_key_row(CFG_KEY_ROW_ONE, r1);
    load_key_row(CFG_KEY_ROW_TWO, r2);
    key_loads++;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z));
    if (r < 90) return 8'h20;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_reset_key();
    send_text_string("hello", 1'b1);
    wait_drain();
  endtask

  task automatic test_saturated_key();
    load_key(15'h7fff, 15'h7fff, 15'h7fff);
    send_text_string("zzaz", 1'b1);
    wait_drain();
  endtask

  task automatic test_directed_cases();
    load_key(15'd6 | (15'd24 << 5) | (15'd1 << 10),
             15'd13 | (15'd16 << 5) | (15'd10 << 10),
             15'd20 | (15'd17 << 5) | (15'd15 << 10));
    send_text_string("act", 1'b0);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hff, 1'b0);
    send_text_byte(8'h60, 1'b0);
    send_text_byte(8'h7b, 1'b0);
    send_text_string("az", 1'b0);
    send_text_byte(8'h7b, 1'b1);
    send_text_byte(8'h20, 1'b1);
    send_text_byte("q", 1'b1);
    send_text_string("xyz", 1'b1);
    send_text_string("mn", 1'b1);
    send_text_string("a b", 1'b0);
    send_text_byte(8'h41, 1'b1);
    wait_drain();
  endtask

  // fill the block while the output is held off
  task automatic test_backpressure_fill();
    load_key(15'($urandom_range(32767)), 15'($urandom_range(32767)),
             15'($urandom_range(32767)));
    hold_left <= 200;
    @(posedge clk);
    for (int i = 0; i < 40; i++)
      send_text_byte(8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z)), i == 39);
    wait_drain();
  endtask

  task automatic test_pause_mid_group();
    send_text_string("pqrst", 1'b0);
    wait_drain();
    send_text_string("uvw", 1'b1);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int send_idle, input int recv_stall, input int n);
    wait_drain();
    load_key(15'($urandom_range(32767)), 15'($urandom_range(32767)),
             15'($urandom_range(32767)));
    idle_pct = send_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < n; i++)
      send_text_byte(pick_text_byte(), $urandom_range(99) < 8);
    send_text_byte(pick_text_byte(), 1'b1);
    wait_drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_saturated_key();
    test_directed_cases();
    test_backpressure_fill();
    test_pause_mid_group();
    test_random_traffic(0, 0, 45);
    test_random_traffic(55, 0, 45);
    test_random_traffic(0, 55, 45);
    test_random_traffic(6, 6, 45);
    load_key(15'h0000, 15'h0000, 15'h0000);
    wait_drain();
    $display("Run covered %0d text bytes under %0d keys, zero and saturated keys included,",
             bytes_sent, key_loads);
    $display("with %0d cipher letters checked through idle, stall and hold-off phases.",
             letters_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
